>>> src/bmh_pkg.sv
// shared types and constants for the bounded max-heap
package bmh_pkg;

   localparam int KEY_W = 32;
   localparam int CNT_W = 7;
   // heap positions are 1-based; one spare bit holds a child position
   localparam int POS_W = CNT_W + 1;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [CNT_W-1:0]        count_type;
   typedef logic [POS_W-1:0]        pos_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef struct packed {
      logic    wr_en;
      pos_type wr_pos;
      key_type wr_data;
      logic    rd_en;
      pos_type rd_pos_a;
      pos_type rd_pos_b;
   } mem_req_type;

   localparam key_type EMPTY_TOP = -32'sd1;
   localparam pos_type ROOT_POS  = 8'd1;

endpackage

>>> src/bmh_store.sv
// heap key memory: one write port, two registered read ports, addressed by heap position
module bmh_store #(
   parameter int HEAP_DEPTH = 64
) (
   input  logic                clock,
   input  bmh_pkg::mem_req_type mem_req,
   output bmh_pkg::key_type     rd_data_a,
   output bmh_pkg::key_type     rd_data_b
);
   import bmh_pkg::*;

   localparam int ADDR_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;

   key_type heap_mem_ff [HEAP_DEPTH];
   key_type rd_a_ff;
   key_type rd_b_ff;

   // position 1 lives at address 0
   function automatic logic [ADDR_W-1:0] pos_to_addr(input pos_type pos);
      logic [ADDR_W+POS_W-1:0] ext;
      ext = (ADDR_W+POS_W)'(pos - ROOT_POS);
      return ext[ADDR_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         heap_mem_ff[pos_to_addr(mem_req.wr_pos)] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_a_ff <= heap_mem_ff[pos_to_addr(mem_req.rd_pos_a)];
         rd_b_ff <= heap_mem_ff[pos_to_addr(mem_req.rd_pos_b)];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> src/bmh_ctrl.sv
// heap sequencer: sift up and sift down over the key memory, result word register
module bmh_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  bmh_pkg::count_type    eff_capacity,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  bmh_pkg::key_type      req_key,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_displaced_valid,
   output bmh_pkg::key_type      rsp_displaced_value,
   output bmh_pkg::key_type      rsp_top_value,
   output bmh_pkg::count_type    rsp_kept_count,
   output logic                  rsp_empty_error,
   output bmh_pkg::mem_req_type  mem_req,
   input  bmh_pkg::key_type      rd_data_a,
   input  bmh_pkg::key_type      rd_data_b
);
   import bmh_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LAST_RD,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_CMP,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   pos_type   pos_ff, pos_in;
   key_type   val_ff, val_in;
   key_type   top_ff, top_in;
   logic      disp_valid_ff, disp_valid_in;
   key_type   disp_value_ff, disp_value_in;
   logic      err_ff, err_in;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_disp_valid_ff, rsp_disp_valid_in;
   key_type   rsp_disp_value_ff, rsp_disp_value_in;
   key_type   rsp_top_ff, rsp_top_in;
   count_type rsp_count_ff, rsp_count_in;
   logic      rsp_err_ff, rsp_err_in;

   logic      accept;
   pos_type   count_pos;
   pos_type   child;
   logic      pick_b;
   key_type   child_val;
   pos_type   child_pos;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign count_pos = pos_type'(count_ff);
   assign child     = pos_ff << 1;
   // right child wins only if it exists and is strictly larger
   assign pick_b    = (child < count_pos) && (rd_data_b > rd_data_a);
   assign child_val = pick_b ? rd_data_b : rd_data_a;
   assign child_pos = pick_b ? (child + ROOT_POS) : child;

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      pos_in            = pos_ff;
      val_in            = val_ff;
      top_in            = top_ff;
      disp_valid_in     = disp_valid_ff;
      disp_value_in     = disp_value_ff;
      err_in            = err_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_disp_valid_in = rsp_disp_valid_ff;
      rsp_disp_value_in = rsp_disp_value_ff;
      rsp_top_in        = rsp_top_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_err_in        = rsp_err_ff;
      mem_req           = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               disp_valid_in = 1'b0;
               disp_value_in = '0;
               err_in        = 1'b0;
               if (req_op == OP_INSERT) begin
                  if (count_ff < eff_capacity) begin
                     count_in = count_ff + count_type'(1);
                     pos_in   = count_pos + ROOT_POS;
                     val_in   = req_key;
                     state_in = S_UP_RD;
                  end else if (req_key < top_ff) begin
                     disp_valid_in = 1'b1;
                     disp_value_in = top_ff;
                     val_in        = req_key;
                     pos_in        = ROOT_POS;
                     state_in      = S_DN_RD;
                  end else begin
                     disp_valid_in = 1'b1;
                     disp_value_in = req_key;
                     state_in      = S_RESP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     err_in   = 1'b1;
                     state_in = S_RESP;
                  end else begin
                     disp_valid_in = 1'b1;
                     disp_value_in = top_ff;
                     count_in      = count_ff - count_type'(1);
                     if (count_ff == count_type'(1)) begin
                        state_in = S_RESP;
                     end else begin
                        // fetch the last key, it refills the root
                        mem_req.rd_en    = 1'b1;
                        mem_req.rd_pos_a = count_pos;
                        mem_req.rd_pos_b = count_pos;
                        state_in         = S_LAST_RD;
                     end
                  end
               end
            end
         end
         S_LAST_RD: begin
            val_in   = rd_data_a;
            pos_in   = ROOT_POS;
            state_in = S_DN_RD;
         end
         S_UP_RD: begin
            if (pos_ff == ROOT_POS) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_pos  = pos_ff;
               mem_req.wr_data = val_ff;
               state_in        = S_RESP;
            end else begin
               mem_req.rd_en    = 1'b1;
               mem_req.rd_pos_a = pos_ff >> 1;
               mem_req.rd_pos_b = pos_ff >> 1;
               state_in         = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            mem_req.wr_en  = 1'b1;
            mem_req.wr_pos = pos_ff;
            if (val_ff > rd_data_a) begin
               // parent moves down into the hole
               mem_req.wr_data = rd_data_a;
               pos_in          = pos_ff >> 1;
               state_in        = S_UP_RD;
            end else begin
               mem_req.wr_data = val_ff;
               state_in        = S_RESP;
            end
         end
         S_DN_RD: begin
            if (child > count_pos) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_pos  = pos_ff;
               mem_req.wr_data = val_ff;
               state_in        = S_RESP;
            end else begin
               mem_req.rd_en    = 1'b1;
               mem_req.rd_pos_a = child;
               mem_req.rd_pos_b = child + ROOT_POS;
               state_in         = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            mem_req.wr_en  = 1'b1;
            mem_req.wr_pos = pos_ff;
            if (val_ff >= child_val) begin
               mem_req.wr_data = val_ff;
               state_in        = S_RESP;
            end else begin
               // larger child moves up into the hole
               mem_req.wr_data = child_val;
               pos_in          = child_pos;
               state_in        = S_DN_RD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_disp_valid_in = disp_valid_ff;
               rsp_disp_value_in = disp_value_ff;
               rsp_top_in        = (count_ff == '0) ? EMPTY_TOP : top_ff;
               rsp_count_in      = count_ff;
               rsp_err_in        = err_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // root cache follows every write to position 1
      if (mem_req.wr_en && (mem_req.wr_pos == ROOT_POS)) begin
         top_in = mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff            <= pos_in;
      val_ff            <= val_in;
      top_ff            <= top_in;
      disp_valid_ff     <= disp_valid_in;
      disp_value_ff     <= disp_value_in;
      err_ff            <= err_in;
      rsp_disp_valid_ff <= rsp_disp_valid_in;
      rsp_disp_value_ff <= rsp_disp_value_in;
      rsp_top_ff        <= rsp_top_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_err_ff        <= rsp_err_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_displaced_valid = rsp_disp_valid_ff;
   assign rsp_displaced_value = rsp_disp_value_ff;
   assign rsp_top_value       = rsp_top_ff;
   assign rsp_kept_count      = rsp_count_ff;
   assign rsp_empty_error     = rsp_err_ff;

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_INSERT && count_ff < eff_capacity)
      |=> count_ff == $past(count_ff) + count_type'(1))
      else $error("insert with room did not grow the heap");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (mem_req.wr_pos != '0) && (mem_req.wr_pos <= count_pos))
      else $error("memory write outside the live heap");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after taking a word");

   a_err_no_disp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> !rsp_disp_valid_ff && (rsp_count_ff == '0))
      else $error("empty error reported with a displaced key or keys held");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_count_ff == '0) |-> rsp_top_ff == EMPTY_TOP)
      else $error("empty heap reported a top key");

endmodule

>>> src/bounded_max_heap_k_smallest.sv
// bounded max-heap keeping the smallest keys: capacity register, sequencer and key memory
//
//   channel  ports                      direction  moves
//   req      req_valid/ready, op, key   in         one insert or remove word
//   rsp      rsp_valid/ready, 5 fields  out        one result word per request
//   csr      csr_wr_en, csr_wr_data     in         capacity, no wait
//
// a request walks the heap one level at a time (memory read, then compare
// and write back), plus entry, last write and result steps; a refused key
// or empty remove passes only through entry and result.
// the walk is paced by the single key memory and its registered read ports.
// reset empties the heap and sets capacity to 64; no clearing pass.
// one request at a time; a finished result waits in the output register while
// the next request is taken and worked on.
module bounded_max_heap_k_smallest #(
   parameter int HEAP_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  bmh_pkg::key_type     req_key,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_displaced_valid,
   output bmh_pkg::key_type     rsp_displaced_value,
   output bmh_pkg::key_type     rsp_top_value,
   output bmh_pkg::count_type   rsp_kept_count,
   output logic                 rsp_empty_error,
   input  logic                 csr_wr_en,
   input  bmh_pkg::count_type   csr_wr_data
);
   import bmh_pkg::*;

   localparam count_type DEPTH_CLIP =
      (HEAP_DEPTH > 127) ? count_type'(127) : count_type'(HEAP_DEPTH);
   localparam count_type CAP_RESET = count_type'(64);

   count_type   capacity_ff;
   count_type   eff_capacity;
   mem_req_type mem_req;
   key_type     rd_data_a;
   key_type     rd_data_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // zero acts as one, anything above the memory depth as the depth
   always_comb begin
      if (capacity_ff == '0) begin
         eff_capacity = count_type'(1);
      end else if (capacity_ff > DEPTH_CLIP) begin
         eff_capacity = DEPTH_CLIP;
      end else begin
         eff_capacity = capacity_ff;
      end
   end

   bmh_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .eff_capacity        (eff_capacity),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_key             (req_key),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_displaced_valid (rsp_displaced_valid),
      .rsp_displaced_value (rsp_displaced_value),
      .rsp_top_value       (rsp_top_value),
      .rsp_kept_count      (rsp_kept_count),
      .rsp_empty_error     (rsp_empty_error),
      .mem_req             (mem_req),
      .rd_data_a           (rd_data_a),
      .rd_data_b           (rd_data_b)
   );

   bmh_store #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_store (
      .clock     (clock),
      .mem_req   (mem_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

endmodule

>>> tb/tb_bounded_max_heap_k_smallest.sv
// testbench for the bounded max-heap: directed and random insert/remove traffic against a heap model
`timescale 1ns / 100ps

module tb_bounded_max_heap_k_smallest;
   import bmh_pkg::*;

   localparam int HEAP_DEPTH   = 64;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_WORDS  = 110;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN
   } ready_mode_type;

   typedef struct packed {
      logic      displaced_valid;
      key_type   displaced_value;
      key_type   top_value;
      count_type kept_count;
      logic      empty_error;
   } heap_result_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   logic      req_op = OP_INSERT;
   key_type   req_key = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_displaced_valid;
   key_type   rsp_displaced_value;
   key_type   rsp_top_value;
   count_type rsp_kept_count;
   logic      rsp_empty_error;
   logic      csr_wr_en = 1'b0;
   count_type csr_wr_data = '0;

   // heap model state
   key_type   heap_keys [1:HEAP_DEPTH];
   int        heap_len = 0;
   count_type capacity_reg = count_type'(64);

   heap_result_type pending_heap_results [$];
   int             error_count = 0;
   int             cycle_count = 0;

   // sender and receiver pacing
   int             gap_max = 0;
   int             burst_left = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   logic [31:0]    ready_bits = '1;
   int             ready_tick = 0;

   bounded_max_heap_k_smallest #(
      .HEAP_DEPTH(HEAP_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_key            (req_key),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_displaced_valid(rsp_displaced_valid),
      .rsp_displaced_value(rsp_displaced_value),
      .rsp_top_value      (rsp_top_value),
      .rsp_kept_count     (rsp_kept_count),
      .rsp_empty_error    (rsp_empty_error),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // restore heap order from the root downwards
   function automatic void sink_root();
      int      pos;
      int      child;
      key_type tmp;
      pos = 1;
      while (2 * pos <= heap_len) begin
         child = 2 * pos;
         if (child < heap_len && heap_keys[child + 1] > heap_keys[child]) child++;
         if (heap_keys[pos] >= heap_keys[child]) break;
         tmp = heap_keys[pos];
         heap_keys[pos] = heap_keys[child];
         heap_keys[child] = tmp;
         pos = child;
      end
   endfunction

   function automatic heap_result_type apply_heap_op(input op_type op, input key_type key);
      heap_result_type r;
      int              limit;
      int              pos;
      key_type         tmp;
      r = '0;
      // out-of-range capacity is clamped to 1..depth
      if (capacity_reg == 0) limit = 1;
      else if (int'(capacity_reg) > HEAP_DEPTH) limit = HEAP_DEPTH;
      else limit = int'(capacity_reg);
      if (op == OP_INSERT) begin
         if (heap_len < limit) begin
            heap_len++;
            heap_keys[heap_len] = key;
            pos = heap_len;
            while (pos > 1 && heap_keys[pos] > heap_keys[pos / 2]) begin
               tmp = heap_keys[pos];
               heap_keys[pos] = heap_keys[pos / 2];
               heap_keys[pos / 2] = tmp;
               pos = pos / 2;
            end
         end else if (key < heap_keys[1]) begin
            r.displaced_valid = 1'b1;
            r.displaced_value = heap_keys[1];
            heap_keys[1] = key;
            sink_root();
         end else begin
            // full and not smaller than the maximum: refused
            r.displaced_valid = 1'b1;
            r.displaced_value = key;
         end
      end else if (heap_len == 0) begin
         r.empty_error = 1'b1;
      end else begin
         r.displaced_valid = 1'b1;
         r.displaced_value = heap_keys[1];
         heap_keys[1] = heap_keys[heap_len];
         heap_len--;
         sink_root();
      end
      r.top_value  = (heap_len == 0) ? EMPTY_TOP : heap_keys[1];
      r.kept_count = count_type'(heap_len);
      return r;
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      case (ready_mode)
         READY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         READY_RANDOM: begin
            rsp_ready <= ($urandom_range(3) != 0);
         end
         default: begin
            rsp_ready <= ready_bits[0];
            if (ready_tick == 31) begin
               ready_bits <= $urandom;
               ready_tick <= 0;
            end else begin
               ready_bits <= {ready_bits[0], ready_bits[31:1]};
               ready_tick <= ready_tick + 1;
            end
         end
      endcase
   end

   // result checker
   always @(posedge clock) begin
      heap_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_heap_results.size() == 0) begin
            $error("unexpected result word: no expectation pending");
            error_count++;
         end else begin
            exp_r = pending_heap_results.pop_front();
            if (rsp_displaced_valid !== exp_r.displaced_valid) begin
               $error("displaced_valid: expected %0d, got %0d",
                      exp_r.displaced_valid, rsp_displaced_valid);
               error_count++;
            end
            if (rsp_displaced_value !== exp_r.displaced_value) begin
               $error("displaced_value: expected %0d, got %0d",
                      $signed(exp_r.displaced_value), $signed(rsp_displaced_value));
               error_count++;
            end
            if (rsp_top_value !== exp_r.top_value) begin
               $error("top_value: expected %0d, got %0d",
                      $signed(exp_r.top_value), $signed(rsp_top_value));
               error_count++;
            end
            if (rsp_kept_count !== exp_r.kept_count) begin
               $error("kept_count: expected %0d, got %0d",
                      exp_r.kept_count, rsp_kept_count);
               error_count++;
            end
            if (rsp_empty_error !== exp_r.empty_error) begin
               $error("empty_error: expected %0d, got %0d",
                      exp_r.empty_error, rsp_empty_error);
               error_count++;
            end
         end
      end
   end

   // offer one request word and record its expected result once accepted
   task automatic send_word(input op_type op, input key_type key);
      int gap;
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      do @(posedge clock); while (!req_ready);
      pending_heap_results.push_back(apply_heap_op(op, key));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         if (gap_max > 0) begin
            gap = $urandom_range(1, gap_max);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_heap_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_capacity(input int value);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count_type'(value);
      @(posedge clock);
      capacity_reg = count_type'(value);
      csr_wr_en <= 1'b0;
   endtask

   function automatic key_type pick_key();
      case ($urandom_range(9))
         5, 6, 7: pick_key = key_type'($urandom_range(40)) - 20;
         8: begin
            case ($urandom_range(3))
               0: pick_key = {1'b1, 31'd0};
               1: pick_key = {1'b0, {31{1'b1}}};
               2: pick_key = '0;
               default: pick_key = '1;
            endcase
         end
         // equal to the current maximum
         9: pick_key = (heap_len > 0) ? heap_keys[1] : key_type'($urandom);
         default: pick_key = key_type'($urandom);
      endcase
   endfunction

   task automatic test_empty_remove();
      send_word(OP_REMOVE, key_type'($urandom));
      send_word(OP_REMOVE, '1);
   endtask

   task automatic test_key_extremes();
      send_word(OP_INSERT, {1'b1, 31'd0});
      send_word(OP_INSERT, {1'b0, {31{1'b1}}});
      send_word(OP_INSERT, '0);
      send_word(OP_INSERT, '1);
      repeat (5) send_word(OP_REMOVE, '0);
      // a second remove past empty
      send_word(OP_REMOVE, '0);
   endtask

   task automatic test_full_replace();
      set_capacity(1);
      send_word(OP_INSERT, 5);
      send_word(OP_INSERT, 3);
      send_word(OP_INSERT, 3);
      send_word(OP_INSERT, 9);
      send_word(OP_REMOVE, '0);
      // zero capacity behaves as one
      set_capacity(0);
      send_word(OP_INSERT, 2);
      send_word(OP_INSERT, 7);
      send_word(OP_REMOVE, '0);
   endtask

   task automatic test_capacity_below_count();
      set_capacity(64);
      for (int i = 1; i <= 6; i++) send_word(OP_INSERT, key_type'(10 * i));
      set_capacity(3);
      send_word(OP_INSERT, 5);
      send_word(OP_INSERT, 70);
      send_word(OP_INSERT, 50);
   endtask

   task automatic test_random_traffic();
      int caps [RANDOM_PHASES] = '{3, 1, 64, 0, 8, 127, 2, 17, 100, 31, 64, 5};
      int remove_pct;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_capacity(caps[phase]);
         case (phase % 3)
            0: gap_max = 0;
            1: gap_max = 4;
            default: gap_max = 20;
         endcase
         ready_mode = ready_mode_type'((phase + phase / 3) % 3);
         remove_pct = (caps[phase] >= 64) ? 15 : $urandom_range(20, 55);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // hold the sender until the heap has answered everything
            if (n == PHASE_WORDS / 2) wait_for_results();
            if ($urandom_range(99) < remove_pct) send_word(OP_REMOVE, key_type'($urandom));
            else send_word(OP_INSERT, pick_key());
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_remove();
      test_key_extremes();
      test_full_replace();
      test_capacity_below_count();
      test_random_traffic();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
